@@ src/cfcm_pkg.sv @@
// shared types and codes for the face centre matcher
package cfcm_pkg;

	localparam int DIST_BITS = 52;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	typedef enum logic [1:0] {
		MODE_LOAD_B = 2'd0,
		MODE_LOAD_A = 2'd1,
		MODE_MATCH  = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_MISMATCH = 3'd1,
		ST_BAD_IDX  = 3'd2,
		ST_NONE     = 3'd3,
		ST_TOO_FAR  = 3'd4
	} status_t;

	localparam logic REG_TOL_SHIFT = 1'b0;
	localparam logic REG_MIN_TOL   = 1'b1;

endpackage

@@ src/conformal_face_centre_matcher_unit.sv @@
// top level of the conformal face centre matcher
//
// usage: one input stream (s_axis_*) carries items of mode, position, owner cell and
// query index; one output stream (m_axis_*) returns a result item for each match.
// loads (mode 0 and 1) and clear (mode 3) give no result.
// a load is taken in the idle state, so loads can follow back to back; a clear starts
// a sweep over the taken-bit memory, during which no item is accepted.
// a match reads the queried A face, then scans every stored B face through
// the B store's read port, one face a cycle, then works out the tolerance;
// a new item is taken only once the result of the match has been taken.
// after reset the block runs the same clearing sweep before taking its first item;
// configuration writes are taken at any time.
// the result is held in an output register; while the receiver stalls the
// block finishes nothing more and accepts no new item until the result is taken.
// tdata of s_axis: mode, pos_x, pos_y, pos_z, owner_cell, query_face (lowest first)
// tdata of m_axis: status, cell_a, cell_b, matched_face, best_dist_sq (lowest first)
module conformal_face_centre_matcher_unit #(
	parameter int MAX_FACES  = 1024,
	parameter int COORD_BITS = 24,
	parameter int CELL_BITS  = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// mode, pos_x, pos_y, pos_z, owner_cell, query_face
	input  logic [((2 + 3*COORD_BITS + CELL_BITS
		+ ((MAX_FACES > 1) ? $clog2(MAX_FACES) : 1) + 7)/8)*8-1:0]
		s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// status, cell_a, cell_b, matched_face, best_dist_sq
	output logic [((3 + 2*CELL_BITS + ((MAX_FACES > 1) ? $clog2(MAX_FACES) : 1)
		+ cfcm_pkg::DIST_BITS + 7)/8)*8-1:0]
		m_axis_tdata,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [31:0] cfg_wdata
);
	import cfcm_pkg::*;

	localparam int IW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;  // memory address
	localparam int QW = IW;                                        // query/face field
	localparam int CW = $clog2(MAX_FACES + 1);                     // count width
	localparam int SW = COORD_BITS + 1;                            // span width
	localparam int PW = 2*SW;                                      // square width
	localparam int EW = 3*COORD_BITS + CELL_BITS;                  // store entry width
	localparam int OB = 3 + 2*CELL_BITS + QW + DIST_BITS;
	localparam int OBP = ((OB + 7)/8)*8;
	localparam logic signed [COORD_BITS-1:0] CPOS = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] CNEG = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic [CW-1:0] CMAX = CW'(MAX_FACES);

	// input unpacking
	mode_t in_mode;
	logic signed [COORD_BITS-1:0] in_pos [3];
	logic [CELL_BITS-1:0] in_cell;
	logic [QW-1:0] in_query;
	assign in_mode   = mode_t'(s_axis_tdata[1:0]);
	assign in_pos[0] = s_axis_tdata[2 +: COORD_BITS];
	assign in_pos[1] = s_axis_tdata[2 + COORD_BITS +: COORD_BITS];
	assign in_pos[2] = s_axis_tdata[2 + 2*COORD_BITS +: COORD_BITS];
	assign in_cell   = s_axis_tdata[2 + 3*COORD_BITS +: CELL_BITS];
	assign in_query  = s_axis_tdata[2 + 3*COORD_BITS + CELL_BITS +: QW];

	typedef enum logic [3:0] {
		S_SWEEP, S_IDLE, S_AREAD, S_SCAN, S_LAST, S_DIAG, S_TOL, S_DEC, S_WRITE, S_OUT
	} state_t;
	state_t state_q;

	// configuration
	logic [5:0]  tol_shift_q;
	logic [31:0] min_tol_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_shift_q <= 6'd40;
			min_tol_q   <= 32'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TOL_SHIFT: tol_shift_q <= cfg_wdata[5:0];
				REG_MIN_TOL:   min_tol_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// face stores: entry holds z, y, x, cell (cell lowest)
	logic [EW-1:0] mem_a [MAX_FACES];
	logic [EW-1:0] mem_b [MAX_FACES];
	logic          mem_t [MAX_FACES];
	logic [EW-1:0] rd_a, rd_b;
	logic          rd_t;
	logic          wa_en, wb_en, wt_en, wt_val;
	logic [IW-1:0] wa_addr, wb_addr, ra_addr, rb_addr, wt_addr;
	logic [EW-1:0] w_entry;

	assign w_entry = {in_pos[2], in_pos[1], in_pos[0], in_cell};

	always_ff @(posedge clk) begin
		if (wa_en) mem_a[wa_addr] <= w_entry;
		rd_a <= mem_a[ra_addr];
	end
	always_ff @(posedge clk) begin
		if (wb_en) mem_b[wb_addr] <= w_entry;
		rd_b <= mem_b[rb_addr];
	end
	always_ff @(posedge clk) begin
		if (wt_en) mem_t[wt_addr] <= wt_val;
		rd_t <= mem_t[rb_addr];
	end

	// control registers
	logic [CW-1:0] count_a_q, count_b_q;
	logic signed [COORD_BITS-1:0] a_lo_q [3], a_hi_q [3], b_lo_q [3], b_hi_q [3];
	logic [CW-1:0] scan_q;        // next address to issue
	logic [CW-1:0] sweep_q;
	logic          rv_s1;         // read data valid in scan
	logic [IW-1:0] ridx_s1;
	logic          dv_s2;         // distance stage valid
	logic          dtk_s2;
	logic [IW-1:0] didx_s2;
	logic [PW-1:0] sq_s2 [3];
	logic [EW-1:0] a_ent_q;
	logic          found_q;
	logic [DIST_BITS-1:0] best_q;
	logic [IW-1:0] face_q;
	logic [DIST_BITS-1:0] da_q, db_q, tol_q;
	logic [OB-1:0] out_q;

	// helpers
	function automatic logic [PW-1:0] sq_span(
		input logic signed [COORD_BITS-1:0] lo, input logic signed [COORD_BITS-1:0] hi);
		logic signed [SW-1:0] d;
		logic [SW-1:0] u;
		d = SW'(hi) - SW'(lo);
		u = d;
		if (hi <= lo) return '0;
		return PW'(u) * PW'(u);
	endfunction

	function automatic logic [DIST_BITS-1:0] sat3(
		input logic [PW-1:0] a, input logic [PW-1:0] b, input logic [PW-1:0] c);
		logic [PW+1:0] s;
		s = (PW+2)'(a) + (PW+2)'(b) + (PW+2)'(c);
		if (s > (PW+2)'(DIST_MAX)) return DIST_MAX;
		return DIST_BITS'(s);
	endfunction

	// coordinate k of a stored entry
	function automatic logic signed [COORD_BITS-1:0] ent_pos(
		input logic [EW-1:0] e, input int k);
		return e[CELL_BITS + k*COORD_BITS +: COORD_BITS];
	endfunction

	// distance stage from registered reads
	logic [PW-1:0] sq_c [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [COORD_BITS-1:0] pa, pb;
			pa = ent_pos(a_ent_q, k);
			pb = ent_pos(rd_b, k);
			sq_c[k] = (pa < pb) ? sq_span(pa, pb) : sq_span(pb, pa);
		end
	end
	logic [DIST_BITS-1:0] d_c;
	assign d_c = sat3(sq_s2[0], sq_s2[1], sq_s2[2]);

	// box diagonals
	logic [PW-1:0] sda_c [3], sdb_c [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sda_c[k] = sq_span(a_lo_q[k], a_hi_q[k]);
			sdb_c[k] = sq_span(b_lo_q[k], b_hi_q[k]);
		end
	end
	logic [DIST_BITS-1:0] dmax_c, tshift_c;
	assign dmax_c   = (da_q > db_q) ? da_q : db_q;
	assign tshift_c = dmax_c >> tol_shift_q;

	assign s_axis_tready = (state_q == S_IDLE);
	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;

	// memory addressing
	always_comb begin
		wa_en   = acc && in_mode == MODE_LOAD_A && count_a_q < CMAX;
		wb_en   = acc && in_mode == MODE_LOAD_B && count_b_q < CMAX;
		wa_addr = count_a_q[IW-1:0];
		wb_addr = count_b_q[IW-1:0];
		ra_addr = in_query;
		rb_addr = (state_q == S_DEC || state_q == S_TOL) ? face_q : scan_q[IW-1:0];
		wt_en   = 1'b0;
		wt_val  = 1'b0;
		wt_addr = sweep_q[IW-1:0];
		if (state_q == S_SWEEP) begin
			wt_en = 1'b1;
		end else if (state_q == S_WRITE) begin
			wt_en   = (out_q[2:0] == 3'(ST_OK));
			wt_val  = 1'b1;
			wt_addr = face_q;
		end
	end

	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata  = OBP'(out_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_SWEEP;
			sweep_q   <= '0;
			count_a_q <= '0;
			count_b_q <= '0;
			for (int k = 0; k < 3; k++) begin
				a_lo_q[k] <= CPOS; a_hi_q[k] <= CNEG;
				b_lo_q[k] <= CPOS; b_hi_q[k] <= CNEG;
			end
			scan_q  <= '0;
			rv_s1   <= 1'b0;
			dv_s2   <= 1'b0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == CMAX - 1'b1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					sweep_q <= '0;
					if (acc) begin
						unique case (in_mode)
							MODE_LOAD_A: if (count_a_q < CMAX) begin
								count_a_q <= count_a_q + 1'b1;
								for (int k = 0; k < 3; k++) begin
									if (in_pos[k] < a_lo_q[k]) a_lo_q[k] <= in_pos[k];
									if (in_pos[k] > a_hi_q[k]) a_hi_q[k] <= in_pos[k];
								end
							end
							MODE_LOAD_B: if (count_b_q < CMAX) begin
								count_b_q <= count_b_q + 1'b1;
								for (int k = 0; k < 3; k++) begin
									if (in_pos[k] < b_lo_q[k]) b_lo_q[k] <= in_pos[k];
									if (in_pos[k] > b_hi_q[k]) b_hi_q[k] <= in_pos[k];
								end
							end
							MODE_CLEAR: begin
								count_a_q <= '0;
								count_b_q <= '0;
								for (int k = 0; k < 3; k++) begin
									a_lo_q[k] <= CPOS; a_hi_q[k] <= CNEG;
									b_lo_q[k] <= CPOS; b_hi_q[k] <= CNEG;
								end
								state_q <= S_SWEEP;
							end
							MODE_MATCH: begin
								if (count_a_q != count_b_q) begin
									out_q   <= OB'(ST_MISMATCH);
									state_q <= S_OUT;
								end else if (CW'(in_query) >= count_a_q) begin
									out_q   <= OB'(ST_BAD_IDX);
									state_q <= S_OUT;
								end else begin
									state_q <= S_AREAD;
								end
							end
							default: ;
						endcase
					end
				end
				S_AREAD: begin
					a_ent_q <= rd_a;
					scan_q  <= '0;
					rv_s1   <= 1'b0;
					dv_s2   <= 1'b0;
					found_q <= 1'b0;
					best_q  <= '0;
					face_q  <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN, S_LAST: begin
					// issue address, register read, square, then compare
					if (state_q == S_SCAN && scan_q < count_b_q) begin
						scan_q <= scan_q + 1'b1;
						rv_s1  <= 1'b1;
					end else begin
						rv_s1  <= 1'b0;
					end
					ridx_s1 <= scan_q[IW-1:0];
					dv_s2   <= rv_s1;
					dtk_s2  <= rd_t;
					didx_s2 <= ridx_s1;
					for (int k = 0; k < 3; k++) sq_s2[k] <= sq_c[k];
					if (dv_s2 && !dtk_s2 && (!found_q || d_c < best_q)) begin
						found_q <= 1'b1;
						best_q  <= d_c;
						face_q  <= didx_s2;
					end
					if (state_q == S_SCAN && scan_q >= count_b_q) state_q <= S_LAST;
					if (state_q == S_LAST && !rv_s1 && !dv_s2) state_q <= S_DIAG;
				end
				S_DIAG: begin
					da_q    <= sat3(sda_c[0], sda_c[1], sda_c[2]);
					db_q    <= sat3(sdb_c[0], sdb_c[1], sdb_c[2]);
					state_q <= S_TOL;
				end
				S_TOL: begin
					tol_q   <= (tshift_c < DIST_BITS'(min_tol_q)) ? DIST_BITS'(min_tol_q)
						: tshift_c;
					state_q <= S_DEC;
				end
				S_DEC: begin
					if (!found_q) begin
						out_q <= {DIST_BITS'(0), QW'(0), CELL_BITS'(0),
							a_ent_q[CELL_BITS-1:0], 3'(ST_NONE)};
					end else begin
						out_q <= {best_q, face_q, rd_b[CELL_BITS-1:0],
							a_ent_q[CELL_BITS-1:0],
							(best_q > tol_q) ? 3'(ST_TOO_FAR) : 3'(ST_OK)};
					end
					state_q <= S_WRITE;
				end
				S_WRITE: state_q <= S_OUT;
				S_OUT:   if (m_axis_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a result only leaves from the output state
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> state_q == S_OUT)
		else $error("result valid outside output state");
	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(out_q))
		else $error("result changed while stalled");
	// counts never pass the store depth
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_a_q <= CMAX && count_b_q <= CMAX)
		else $error("face count beyond depth");
	// no item taken during the clearing sweep
	a_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SWEEP |-> !s_axis_tready)
		else $error("item accepted during sweep");

endmodule
